@@ rtl/core/sdf_scene_distance_macros.svh @@
// assertion macros for the scene distance core
// included by modules that carry concurrent checks; expects i_clk and i_rst_n in scope
`ifndef SDF_SCENE_DISTANCE_MACROS_SVH
`define SDF_SCENE_DISTANCE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SDF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sdf check failed");
`define SDF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sdf check failed");
`else
`define SDF_ASSERT_IMP(label, ante, cons)
`define SDF_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ rtl/core/sdf_pkg.sv @@
// shared constants and types for the scene distance core
// no dependencies; used by sdf_isqrt, sdf_scene_distance, the checker and the testbench
`timescale 1ns / 1ps
package sdf_pkg;
    localparam int CfgW   = 15;
    localparam int PosW   = 16;
    localparam int DistW  = 16;
    localparam int AddrW  = 5;
    localparam int DataW  = 32;
    localparam int NumReg = 8;
    localparam int SqInW  = 32;
    localparam int SqOutW = SqInW / 2;
    localparam int WideW  = 18;

    localparam logic [2:0] REG_REP_PERIOD  = 3'd0;
    localparam logic [2:0] REG_BOX_HALF    = 3'd1;
    localparam logic [2:0] REG_BOX_ROUND   = 3'd2;
    localparam logic [2:0] REG_TORUS_MAJOR = 3'd3;
    localparam logic [2:0] REG_TORUS_MINOR = 3'd4;
    localparam logic [2:0] REG_SHELL_THICK = 3'd5;
    localparam logic [2:0] REG_SLAB_HALF   = 3'd6;
    localparam logic [2:0] REG_CLIP_HALF   = 3'd7;

    typedef logic [CfgW-1:0] t_cfg;
    typedef logic signed [WideW-1:0] t_wide;

    localparam t_cfg RST_REP_PERIOD  = 15'd1536;
    localparam t_cfg RST_BOX_HALF    = 15'd410;
    localparam t_cfg RST_BOX_ROUND   = 15'd410;
    localparam t_cfg RST_TORUS_MAJOR = 15'd4096;
    localparam t_cfg RST_TORUS_MINOR = 15'd2458;
    localparam t_cfg RST_SHELL_THICK = 15'd205;
    localparam t_cfg RST_SLAB_HALF   = 15'd2048;
    localparam t_cfg RST_CLIP_HALF   = 15'd7168;
endpackage

@@ rtl/core/sdf_isqrt.sv @@
// pipelined floor square root, two radicand bits per stage
// depends on sdf_pkg for widths
`timescale 1ns / 1ps
module sdf_isqrt (
    input  logic                        i_clk,
    input  logic                        i_ce,
    input  logic [sdf_pkg::SqInW-1:0]   i_rad,
    output logic [sdf_pkg::SqOutW-1:0]  o_root
);
    import sdf_pkg::*;

    localparam int RemW = SqOutW + 4;

    logic [RemW-1:0]   r_rem  [SqOutW];
    logic [SqOutW-1:0] r_root [SqOutW];
    logic [SqInW-1:0]  r_rad  [SqOutW];
    logic [RemW-1:0]   n_rem  [SqOutW];
    logic [SqOutW-1:0] n_root [SqOutW];
    logic [SqInW-1:0]  n_rad  [SqOutW];

    always_comb begin
        logic [RemW-1:0]   rem_in;
        logic [SqOutW-1:0] root_in;
        logic [SqInW-1:0]  rad_in;
        logic [RemW-1:0]   sh;
        logic [RemW-1:0]   trial;
        for (int k = 0; k < SqOutW; k++) begin
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = i_rad;
            end else begin
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
                rad_in  = r_rad[k-1];
            end
            // next two radicand bits enter from the top
            sh    = {rem_in[RemW-3:0], rad_in[SqInW-1 -: 2]};
            trial = {2'b00, root_in, 2'b01};
            n_rad[k] = {rad_in[SqInW-3:0], 2'b00};
            if (sh >= trial) begin
                n_rem[k]  = sh - trial;
                n_root[k] = {root_in[SqOutW-2:0], 1'b1};
            end else begin
                n_rem[k]  = sh;
                n_root[k] = {root_in[SqOutW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < SqOutW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
            end
        end
    end

    assign o_root = r_root[SqOutW-1];
endmodule

@@ rtl/core/sdf_scene_distance.sv @@
// Scene distance core: one signed Q3.12 point in, one saturated distance out per cycle.
// The pipeline is 42 stages deep; the depth is set by the two square roots in series on
// the torus path, each a 16-stage unit. The whole pipeline advances together and holds
// only while a finished result waits on the output. Registers are to be written over
// the APB port only when no point is in flight; the user must keep to this, as the
// block does not enforce it.
// depends on sdf_pkg, sdf_isqrt and sdf_scene_distance_macros.svh
`timescale 1ns / 1ps
module sdf_scene_distance (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // pos_x [15:0], pos_y [31:16], pos_z [47:32]
    input  logic [3*sdf_pkg::PosW-1:0]  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // distance [15:0]
    output logic [sdf_pkg::DistW-1:0]   o_m_axis_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdf_pkg::AddrW-1:0]   paddr,
    input  logic [sdf_pkg::DataW-1:0]   pwdata,
    output logic [sdf_pkg::DataW-1:0]   prdata,
    output logic                        pready
);
    import sdf_pkg::*;
    `include "sdf_scene_distance_macros.svh"

    localparam int Last   = 41;
    localparam int ModLat = PosW;

    // ---------------- configuration registers
    t_cfg r_cfg [NumReg];
    logic [2:0] w_idx;
    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign prdata = {{(DataW-CfgW){1'b0}}, r_cfg[w_idx]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_REP_PERIOD]  <= RST_REP_PERIOD;
            r_cfg[REG_BOX_HALF]    <= RST_BOX_HALF;
            r_cfg[REG_BOX_ROUND]   <= RST_BOX_ROUND;
            r_cfg[REG_TORUS_MAJOR] <= RST_TORUS_MAJOR;
            r_cfg[REG_TORUS_MINOR] <= RST_TORUS_MINOR;
            r_cfg[REG_SHELL_THICK] <= RST_SHELL_THICK;
            r_cfg[REG_SLAB_HALF]   <= RST_SLAB_HALF;
            r_cfg[REG_CLIP_HALF]   <= RST_CLIP_HALF;
        end else if (psel && penable && pwrite) begin
            r_cfg[w_idx] <= pwdata[CfgW-1:0];
        end
    end

    t_cfg w_period;
    assign w_period = r_cfg[REG_REP_PERIOD];

    // ---------------- pipeline control
    logic w_ce;
    logic r_vld [Last+1];
    assign w_ce            = !r_vld[Last] || i_m_axis_tready;
    assign o_s_axis_tready = w_ce;
    assign o_m_axis_tvalid = r_vld[Last];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= Last; k++) r_vld[k] <= 1'b0;
        end else if (w_ce) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k <= Last; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // ---------------- stage 0: absolute coordinates
    logic signed [PosW:0] w_px, w_py, w_pz;
    logic [PosW-1:0] r_ax, r_az;
    logic [PosW-1:0] r_ayd [20];
    assign w_px = {i_s_axis_tdata[PosW-1], i_s_axis_tdata[PosW-1:0]};
    assign w_py = {i_s_axis_tdata[2*PosW-1], i_s_axis_tdata[2*PosW-1:PosW]};
    assign w_pz = {i_s_axis_tdata[3*PosW-1], i_s_axis_tdata[3*PosW-1:2*PosW]};

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ax     <= w_px[PosW] ? PosW'(-w_px) : w_px[PosW-1:0];
            r_ayd[0] <= w_py[PosW] ? PosW'(-w_py) : w_py[PosW-1:0];
            r_az     <= w_pz[PosW] ? PosW'(-w_pz) : w_pz[PosW-1:0];
            for (int k = 1; k < 20; k++) r_ayd[k] <= r_ayd[k-1];
        end
    end

    // ---------------- stage 1: slab and cube distances, delayed to the merge
    t_wide r_slabd [1:40];
    t_wide r_cube  [1:40];
    logic [PosW-1:0] w_amax;
    assign w_amax = (r_ax >= r_ayd[0] && r_ax >= r_az) ? r_ax :
                    (r_ayd[0] >= r_az) ? r_ayd[0] : r_az;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_slabd[1] <= $signed({2'b00, r_ayd[0]})
                        - $signed({3'b000, r_cfg[REG_SLAB_HALF]});
            r_cube[1]  <= $signed({2'b00, w_amax})
                        - $signed({3'b000, r_cfg[REG_CLIP_HALF]});
            for (int k = 2; k <= 40; k++) begin
                r_slabd[k] <= r_slabd[k-1];
                r_cube[k]  <= r_cube[k-1];
            end
        end
    end

    // ---------------- torus path: ring radius
    logic [SqInW-1:0]  r_xx, r_zz, r_sxz;
    logic [SqOutW-1:0] w_ring_root;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_xx  <= r_ax * r_ax;
            r_zz  <= r_az * r_az;
            r_sxz <= r_xx + r_zz;
        end
    end

    sdf_isqrt u_sq_ring (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_rad  (r_sxz),
        .o_root (w_ring_root)
    );

    // stage 19..21: tube radius input
    t_wide r_ring;
    logic [PosW-1:0]  w_ring_abs;
    logic [SqInW-1:0] r_rr, r_yy, r_srr;
    logic [SqOutW-1:0] w_tube;
    assign w_ring_abs = r_ring[WideW-1] ? PosW'(-r_ring) : r_ring[PosW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ring <= $signed({2'b00, w_ring_root})
                    - $signed({3'b000, r_cfg[REG_TORUS_MAJOR]});
            r_rr   <= w_ring_abs * w_ring_abs;
            r_yy   <= r_ayd[19] * r_ayd[19];
            r_srr  <= r_rr + r_yy;
        end
    end

    sdf_isqrt u_sq_tube (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_rad  (r_srr),
        .o_root (w_tube)
    );

    // ---------------- box lattice: restoring remainder, one bit per stage
    logic [PosW-1:0] r_mrem [3][ModLat];
    logic [PosW-1:0] r_mdvd [3][ModLat];
    logic [PosW-1:0] n_mrem [3][ModLat];
    logic [PosW-1:0] w_abs0 [3];
    assign w_abs0[0] = r_ax;
    assign w_abs0[1] = r_ayd[0];
    assign w_abs0[2] = r_az;

    always_comb begin
        logic [PosW-1:0] rem_in;
        logic [PosW-1:0] dvd_in;
        logic [PosW-1:0] t;
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < ModLat; k++) begin
                if (k == 0) begin
                    rem_in = '0;
                    dvd_in = w_abs0[a];
                end else begin
                    rem_in = r_mrem[a][k-1];
                    dvd_in = r_mdvd[a][k-1];
                end
                t = {rem_in[PosW-2:0], dvd_in[PosW-1]};
                n_mrem[a][k] = (t >= {1'b0, w_period}) ? t - {1'b0, w_period} : t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < ModLat; k++) begin
                    r_mrem[a][k] <= n_mrem[a][k];
                    if (k == 0) r_mdvd[a][k] <= {w_abs0[a][PosW-2:0], 1'b0};
                    else        r_mdvd[a][k] <= {r_mdvd[a][k-1][PosW-2:0], 1'b0};
                end
            end
        end
    end

    // stage 17..20: folded coordinate, box excess, squares, sum
    t_wide            w_q   [3];
    logic [PosW-1:0]  r_qa  [3];
    logic signed [PosW:0] w_ex [3];
    logic [CfgW-1:0]  r_dx  [3];
    logic [2*CfgW-1:0] r_dsq [3];
    logic [SqInW-1:0] r_bsum;
    logic [SqOutW-1:0] w_bsq;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_q[a]  = $signed({2'b00, r_mrem[a][ModLat-1]})
                    - $signed({4'b0000, w_period[CfgW-1:1]});
            w_ex[a] = $signed({1'b0, r_qa[a]}) - $signed({2'b00, r_cfg[REG_BOX_HALF]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int a = 0; a < 3; a++) begin
                // a zero period folds every axis to the origin
                if (w_period == '0)          r_qa[a] <= '0;
                else if (w_q[a][WideW-1])   r_qa[a] <= PosW'(-w_q[a]);
                else                        r_qa[a] <= w_q[a][PosW-1:0];
                r_dx[a]  <= w_ex[a][PosW] ? '0 : w_ex[a][CfgW-1:0];
                r_dsq[a] <= r_dx[a] * r_dx[a];
            end
            r_bsum <= SqInW'(r_dsq[0]) + SqInW'(r_dsq[1]) + SqInW'(r_dsq[2]);
        end
    end

    sdf_isqrt u_sq_box (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_rad  (r_bsum),
        .o_root (w_bsq)
    );

    // ---------------- stage 37..41: combine
    t_wide r_box37, r_box38, r_tor;
    t_wide r_res1, r_shell, r_res2;
    t_wide w_tor_abs, w_nbox, w_sh0, w_mn, w_fin;
    logic [DistW-1:0] r_out;

    assign w_tor_abs = r_tor[WideW-1] ? -r_tor : r_tor;
    assign w_nbox    = -r_box38;
    assign w_sh0     = w_tor_abs - $signed({3'b000, r_cfg[REG_SHELL_THICK]});
    assign w_mn      = (r_res1 < r_shell) ? r_res1 : r_shell;
    assign w_fin     = (r_res2 > r_cube[40]) ? r_res2 : r_cube[40];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_box37 <= $signed({2'b00, w_bsq}) - $signed({3'b000, r_cfg[REG_BOX_ROUND]});
            r_box38 <= r_box37;
            r_tor   <= $signed({2'b00, w_tube}) - $signed({3'b000, r_cfg[REG_TORUS_MINOR]});
            r_res1  <= (r_tor > w_nbox) ? r_tor : w_nbox;
            r_shell <= (w_sh0 > r_slabd[38]) ? w_sh0 : r_slabd[38];
            r_res2  <= (w_mn > r_slabd[39]) ? w_mn : r_slabd[39];
            if (w_fin > t_wide'(32767))       r_out <= 16'h7fff;
            else if (w_fin < t_wide'(-32768)) r_out <= 16'h8000;
            else                              r_out <= w_fin[DistW-1:0];
        end
    end

    assign o_m_axis_tdata = r_out;

    // ---------------- checks
    `SDF_ASSERT_NXT(a_take_enters, i_s_axis_tvalid && o_s_axis_tready, r_vld[0])
    `SDF_ASSERT_IMP(a_stall_only_full, !o_s_axis_tready, o_m_axis_tvalid)
    `SDF_ASSERT_NXT(a_last_stage_moves, w_ce && r_vld[Last-1], o_m_axis_tvalid)
    `SDF_ASSERT_NXT(a_hold_on_stall, !w_ce, r_vld[0] == $past(r_vld[0]))
endmodule

@@ test/sdf_scene_distance_checker.sv @@
// checker for the scene distance core: watches both streams and the register port
// predicts each distance from its own register copy; depends on sdf_pkg
`timescale 1ns / 1ps
module sdf_scene_distance_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_valid,
    input  logic                        i_s_ready,
    input  logic [3*sdf_pkg::PosW-1:0]  i_s_data,
    input  logic                        i_m_valid,
    input  logic                        i_m_ready,
    input  logic [sdf_pkg::DistW-1:0]   i_m_data,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [sdf_pkg::AddrW-1:0]   i_paddr,
    input  logic [sdf_pkg::DataW-1:0]   i_pwdata,
    output int                          o_errors,
    output int                          o_pending
);
    import sdf_pkg::*;

    t_cfg shadow [NumReg];
    logic [DistW-1:0] dist_q [$];

    function automatic longint root_floor(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint mag(longint a);
        return a < 0 ? -a : a;
    endfunction

    function automatic longint fold_axis(longint p, longint c, longint h);
        longint q;
        q = (c == 0) ? 0 : (mag(p) % c) - (c >>> 1);
        q = mag(q) - h;
        return q > 0 ? q : 0;
    endfunction

    function automatic logic [DistW-1:0] scene_dist(logic [3*PosW-1:0] d);
        longint x, y, z, per, bh, ring, tor, dx, dy, dz, boxes, res, slabd, shell, cube;
        x = longint'($signed(d[15:0]));
        y = longint'($signed(d[31:16]));
        z = longint'($signed(d[47:32]));
        per = shadow[REG_REP_PERIOD];
        bh = shadow[REG_BOX_HALF];
        ring = root_floor(x * x + z * z) - shadow[REG_TORUS_MAJOR];
        tor = root_floor(ring * ring + y * y) - shadow[REG_TORUS_MINOR];
        dx = fold_axis(x, per, bh);
        dy = fold_axis(y, per, bh);
        dz = fold_axis(z, per, bh);
        boxes = root_floor(dx * dx + dy * dy + dz * dz) - shadow[REG_BOX_ROUND];
        res = tor > -boxes ? tor : -boxes;
        // the larger of y - slab and -y - slab
        slabd = mag(y) - longint'(shadow[REG_SLAB_HALF]);
        shell = mag(tor) - shadow[REG_SHELL_THICK];
        if (slabd > shell) shell = slabd;
        if (shell < res) res = shell;
        if (slabd > res) res = slabd;
        cube = mag(x);
        if (mag(y) > cube) cube = mag(y);
        if (mag(z) > cube) cube = mag(z);
        cube = cube - shadow[REG_CLIP_HALF];
        if (cube > res) res = cube;
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        return res[DistW-1:0];
    endfunction

    assign o_pending = dist_q.size();

    always @(posedge i_clk) begin
        logic [DistW-1:0] want;
        if (!i_rst_n) begin
            shadow[REG_REP_PERIOD]  <= RST_REP_PERIOD;
            shadow[REG_BOX_HALF]    <= RST_BOX_HALF;
            shadow[REG_BOX_ROUND]   <= RST_BOX_ROUND;
            shadow[REG_TORUS_MAJOR] <= RST_TORUS_MAJOR;
            shadow[REG_TORUS_MINOR] <= RST_TORUS_MINOR;
            shadow[REG_SHELL_THICK] <= RST_SHELL_THICK;
            shadow[REG_SLAB_HALF]   <= RST_SLAB_HALF;
            shadow[REG_CLIP_HALF]   <= RST_CLIP_HALF;
            o_errors <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                shadow[i_paddr[4:2]] <= i_pwdata[CfgW-1:0];
            if (i_s_valid && i_s_ready)
                dist_q.push_back(scene_dist(i_s_data));
            if (i_m_valid && i_m_ready) begin
                if (dist_q.size() == 0) begin
                    $display("%0t: unexpected distance transaction, expected none, actual %h",
                             $time, i_m_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = dist_q.pop_front();
                    if (want !== i_m_data) begin
                        $display("%0t: distance mismatch, expected %h, actual %h",
                                 $time, want, i_m_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

@@ test/tb_sdf_scene_distance.sv @@
// stimulus and verdict for the scene distance core: directed and random points,
// register phases between drains; depends on sdf_pkg, sdf_scene_distance and sdf_scene_distance_checker
`timescale 1ns / 1ps
module tb_sdf_scene_distance;
    import sdf_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [3*PosW-1:0] s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [DistW-1:0] m_data;
    logic psel = 0, penable = 0, pwrite = 0, pready;
    logic [AddrW-1:0] paddr = '0;
    logic [DataW-1:0] pwdata = '0, prdata;
    int errors, pending;
    bit feeding = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    sdf_scene_distance u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready), .o_m_axis_tdata(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    sdf_scene_distance_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_valid), .i_s_ready(s_ready), .i_s_data(s_data),
        .i_m_valid(m_valid), .i_m_ready(m_ready), .i_m_data(m_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output stall pattern, bursts of full rate mixed in
    always @(posedge i_clk) begin
        if (feeding && $urandom_range(0, 3) == 0) m_ready <= 1'b1;
        else m_ready <= (gap_len() == 0) || !feeding;
    end

    task automatic reg_write(logic [2:0] idx, logic [DataW-1:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= AddrW'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // valid stays up between back to back points, dropped only for a gap
    task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_valid <= 1;
        s_data <= {z, y, x};
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 16'($signed($urandom_range(0, 16384)) - 8192);
        if (r < 9) return 16'($urandom);
        return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
    endfunction

    task automatic random_phase(int n);
        repeat (n) send_point(rnd_coord(), rnd_coord(), rnd_coord());
    endtask

    initial begin
        #200000;
        $display("tb_sdf_scene_distance NOT OK");
        $finish;
    end

    initial begin
        logic [15:0] ext [6];
        ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h1000, 16'hF000};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        feeding = 1;
        // directed: extremes and points near the torus, slab and box walls
        for (int k = 0; k < 6; k++) send_point(ext[k], ext[(k + 2) % 6], ext[(k + 4) % 6]);
        send_point(16'h8000, 16'h8000, 16'h8000);
        send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_point(16'd4096, 16'd0, 16'd0);
        send_point(16'd6554, 16'd0, 16'd0);
        send_point(16'd0, 16'd2048, 16'd4096);
        send_point(16'd768, 16'd768, 16'd768);
        send_point(16'd7168, 16'd0, 16'd0);
        random_phase(500);
        drain();
        // zero and odd period, extreme sizes
        reg_write(REG_REP_PERIOD, 32'd0);
        reg_write(REG_BOX_HALF, 32'h7FFF);
        reg_write(REG_BOX_ROUND, 32'd0);
        reg_write(REG_TORUS_MAJOR, 32'h7FFF);
        reg_write(REG_TORUS_MINOR, 32'd0);
        reg_write(REG_SHELL_THICK, 32'h7FFF);
        reg_write(REG_SLAB_HALF, 32'h7FFF);
        reg_write(REG_CLIP_HALF, 32'h7FFF);
        random_phase(300);
        drain();
        reg_write(REG_REP_PERIOD, 32'd1);
        reg_write(REG_BOX_HALF, 32'd0);
        reg_write(REG_BOX_ROUND, 32'h7FFF);
        reg_write(REG_TORUS_MAJOR, 32'd0);
        reg_write(REG_TORUS_MINOR, 32'h7FFF);
        reg_write(REG_SHELL_THICK, 32'd0);
        reg_write(REG_SLAB_HALF, 32'd0);
        reg_write(REG_CLIP_HALF, 32'd0);
        random_phase(300);
        drain();
        reg_write(REG_REP_PERIOD, 32'h7FFF);
        random_phase(100);
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            for (int r = 0; r < NumReg; r++) reg_write(3'(r), $urandom);
            reg_write(REG_REP_PERIOD, (ph == 0) ? 32'd1023 : $urandom_range(1, 8191));
            random_phase(170);
            drain();
        end
        feeding = 0;
        drain();
        if (errors == 0) $display("tb_sdf_scene_distance OK");
        else $display("tb_sdf_scene_distance NOT OK");
        $finish;
    end
endmodule

@@ sdf_scene_distance.f @@
+incdir+rtl/core
rtl/core/sdf_pkg.sv
rtl/core/sdf_isqrt.sv
rtl/core/sdf_scene_distance.sv
test/sdf_scene_distance_checker.sv
test/tb_sdf_scene_distance.sv
